// ===== hdl/lru_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU set tracker package
// Shared constants, codes and types of the true-LRU set tracker.
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int WAYS    = 8;
  localparam int WIDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W  = WIDX_W;
  localparam int KIND_W  = 2;
  localparam int WAY_W   = 3;
  localparam int TAG_W   = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TOUCH = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  typedef struct packed {
    logic load_in;
    logic exec;
  } cmd_t;

endpackage

// ===== hdl/lru_ctrl.sv =====
// ----------------------------------------------------------------------------
// LRU set tracker controller
// Sequences capture and execution of one transaction and owns the output
// valid flag.
// ----------------------------------------------------------------------------
module lru_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lru_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o.load_in = 1'b0;
    cmd_o.exec    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/lru_dpath.sv =====
// ----------------------------------------------------------------------------
// LRU set tracker datapath
// Way fields, recency ranks, input capture and result register.
// ----------------------------------------------------------------------------
module lru_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lru_pkg::cmd_t              cmd_i,
  input  logic [lru_pkg::KIND_W-1:0] kind_i,
  input  logic [lru_pkg::WAY_W-1:0]  way_i,
  input  logic                       valid_in_i,
  input  logic                       dirty_in_i,
  input  logic [lru_pkg::TAG_W-1:0]  tag_in_i,
  output logic                       valid_out_o,
  output logic                       dirty_out_o,
  output logic [lru_pkg::TAG_W-1:0]  tag_out_o,
  output logic [lru_pkg::WAY_W-1:0]  lru_way_o
);

  localparam int WAYS   = lru_pkg::WAYS;
  localparam int WIDX_W = lru_pkg::WIDX_W;
  localparam int RANK_W = lru_pkg::RANK_W;
  localparam int WAY_W  = lru_pkg::WAY_W;
  localparam int TAG_W  = lru_pkg::TAG_W;

  lru_pkg::kind_e    kind_q;
  logic [WAY_W-1:0]  way_q;
  logic              vin_q, din_q;
  logic [TAG_W-1:0]  tin_q;

  logic              valid_q [WAYS];
  logic              dirty_q [WAYS];
  logic [TAG_W-1:0]  tag_q   [WAYS];
  logic [RANK_W-1:0] rank_q  [WAYS];

  logic              valid_d [WAYS];
  logic              dirty_d [WAYS];
  logic [TAG_W-1:0]  tag_d   [WAYS];
  logic [RANK_W-1:0] rank_d  [WAYS];

  logic              in_range;
  logic [WIDX_W-1:0] idx;
  logic [RANK_W-1:0] old_rank;
  logic [WAY_W-1:0]  lru_d;

  assign in_range = (32'(way_q) < WAYS);
  assign idx      = WIDX_W'(way_q);
  assign old_rank = rank_q[idx];

  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    tag_d   = tag_q;
    rank_d  = rank_q;
    if (in_range) begin
      case (kind_q)
        lru_pkg::KIND_WRITE: begin
          valid_d[idx] = vin_q;
          dirty_d[idx] = din_q;
          tag_d[idx]   = tin_q;
        end
        lru_pkg::KIND_TOUCH: begin
          for (int v = 0; v < WAYS; v++) begin
            if (rank_q[v] < old_rank) begin
              rank_d[v] = rank_q[v] + RANK_W'(1);
            end
          end
          rank_d[idx] = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    lru_d = '0;
    for (int v = 0; v < WAYS; v++) begin
      if (rank_d[v] == RANK_W'(WAYS - 1)) begin
        lru_d = lru_d | WAY_W'(v);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      kind_q <= lru_pkg::kind_e'(kind_i);
      way_q  <= way_i;
      vin_q  <= valid_in_i;
      din_q  <= dirty_in_i;
      tin_q  <= tag_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < WAYS; v++) begin
        valid_q[v] <= 1'b0;
        dirty_q[v] <= 1'b0;
        tag_q[v]   <= '0;
        rank_q[v]  <= RANK_W'(v);
      end
    end else if (cmd_i.exec) begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      tag_q   <= tag_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      valid_out_o <= in_range ? valid_d[idx] : 1'b0;
      dirty_out_o <= in_range ? dirty_d[idx] : 1'b0;
      tag_out_o   <= in_range ? tag_d[idx]   : '0;
      lru_way_o   <= lru_d;
    end
  end

endmodule

// ===== hdl/lru_cache_set_tracker.sv =====
// ----------------------------------------------------------------------------
// LRU cache set tracker
// One cache set with valid, dirty and tag per way and a true-LRU order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one transaction: kind_i
//   selects read, write of valid/dirty/tag, or touch (make most recent) of
//   way_i. Output channel (out_valid_o / out_stall_i) returns one result per
//   transaction: the addressed way's fields after the step and the current
//   least-recent way. A way beyond the set reports zero fields.
//   Order: the input registers capture the transaction, then the update
//   step writes the result register, held back while a full result is stalled.
//   Flow: a new transaction is accepted only once the previous one has
//   left the update step of the single rank/field update unit.
//   Reset: way 0 is most recent, the last way least recent, all valid,
//   dirty and tag bits clear; no result is pending.
//   Receiver stall: the result register holds; one further transaction is
//   accepted and waits in the update stage until the result is taken.
// ----------------------------------------------------------------------------
module lru_cache_set_tracker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [lru_pkg::KIND_W-1:0] kind_i,
  input  logic [lru_pkg::WAY_W-1:0]  way_i,
  input  logic                       valid_in_i,
  input  logic                       dirty_in_i,
  input  logic [lru_pkg::TAG_W-1:0]  tag_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       valid_out_o,
  output logic                       dirty_out_o,
  output logic [lru_pkg::TAG_W-1:0]  tag_out_o,
  output logic [lru_pkg::WAY_W-1:0]  lru_way_o
);

  lru_pkg::cmd_t cmd;

  lru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lru_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .kind_i      (kind_i),
    .way_i       (way_i),
    .valid_in_i  (valid_in_i),
    .dirty_in_i  (dirty_in_i),
    .tag_in_i    (tag_in_i),
    .valid_out_o (valid_out_o),
    .dirty_out_o (dirty_out_o),
    .tag_out_o   (tag_out_o),
    .lru_way_o   (lru_way_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not held off after accepted transaction");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_valid_o) |=> ##1 out_valid_o)
    else $error("result missing two cycles after transaction");

  a_no_exec_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten while stalled");

  a_lru_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((lru_pkg::WAYS > 8) || (32'(lru_way_o) < lru_pkg::WAYS)))
    else $error("victim way outside the set");

endmodule
